/* sv/gcab_pkg.sv */
// Shared types, sizes and codes for the CSR adjacency builder.
// No dependencies.
package gcab_pkg;
    localparam int MAX_VERTICES = 256;
    localparam int MAX_EDGES    = 512;
    localparam int VW = 8;      // vertex index bits
    localparam int EW = 9;      // edge index bits
    localparam int AW = 10;     // adjacency buffer address bits

    typedef enum logic [1:0] {
        FN_ADD  = 2'd0,
        FN_SLOT = 2'd1,
        FN_VERT = 2'd2,
        FN_NONE = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_VERTEX  = 3'd1,
        ST_FULL    = 3'd2,
        ST_UNBUILT = 3'd3,
        ST_QUERY   = 3'd4
    } t_status;

    // input item fields, highest bit first
    typedef struct packed {
        logic [9:0] query_index;
        logic       last_edge;
        logic [7:0] to_vertex;
        logic [7:0] from_vertex;
        logic [1:0] func;
    } t_in_item;

    // result item fields, highest bit first
    typedef struct packed {
        logic [9:0]  edge_total;
        logic [9:0]  in_count;
        logic [10:0] in_start;
        logic [9:0]  out_count;
        logic [9:0]  out_start;
        logic [8:0]  edge_id;
        logic [2:0]  status;
    } t_out_item;
endpackage

/* sv/gcab_ram.sv */
// Generic single-port-write, one-read synchronous RAM, registered read.
// Depends on nothing.
module gcab_ram #(
    parameter int Depth = 256,
    parameter int Width = 10
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* sv/graph_csr_adjacency_builder.sv */
// Top level of the CSR adjacency builder: load, build sequencer, queries.
// Depends on gcab_pkg and gcab_ram.
//
// Edges load one per item (func 0) into edge memories and get ids in arrival
// order. For loads and queries the accepting cycle presents the query address
// to the memories, then the result register loads once the output side is
// free. An add with last_edge set starts a build, if any edges are held, once
// its result is loaded; the input stays stalled while it runs: clear the
// degree memories for each vertex slot, count degrees with a
// read-modify-write per edge, prefix sums into the offset and cursor memories
// for each vertex slot and scatter of edge ids through the cursors, with one
// out-list and one in-list buffer write per edge. The build is serialised by
// the one read port of each memory. A result waits in the output register;
// tready low holds the next item in its result cycle.
module graph_csr_adjacency_builder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [8:0]  i_cfg_data,         // vertex_count
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,       // from_vertex, to_vertex, query_index
    input  logic [1:0]  s_axis_tuser,       // func
    input  logic        s_axis_tlast,       // last_edge
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata        // status, edge_id, out_start,
                                            // out_count, in_start, in_count,
                                            // edge_total
);
    import gcab_pkg::*;

    localparam logic [VW-1:0] VMAX = VW'(MAX_VERTICES - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_ADD, S_QRY, S_CLR, S_CNT_E, S_CNT_D, S_CNT_W,
        S_SUM_R, S_SUM_W, S_SC_E, S_SC_C, S_SC_WO, S_SC_WI
    } t_state;

    t_state        r_state;
    logic [8:0]    r_vcount;
    logic [9:0]    r_loaded;
    logic          r_built;
    t_in_item      r_item;
    t_out_item     r_res;
    logic          r_ovalid;
    logic [EW-1:0] r_e;         // edge walk counter
    logic [VW-1:0] r_v;         // vertex walk counter
    logic [10:0]   r_run_out;
    logic [10:0]   r_run_in;

    t_in_item w_in;
    assign w_in = {s_axis_tdata[25:16], s_axis_tlast, s_axis_tdata[15:8],
                   s_axis_tdata[7:0], s_axis_tuser};

    // memories
    logic          es_we;
    logic [7:0]    es_rd, et_rd;
    logic          od_we, id_we;
    logic [VW-1:0] od_wa, id_wa, od_ra, id_ra;
    logic [9:0]    od_wd, id_wd, od_rd, id_rd;
    logic          of_we;
    logic [VW-1:0] q_vtx;
    logic [9:0]    oo_rd;
    logic [10:0]   io_rd;
    logic          oc_we, ic_we;
    logic [VW-1:0] oc_wa, ic_wa;
    logic [9:0]    oc_wd, oc_rd;
    logic [10:0]   ic_wd, ic_rd;
    logic          ab_we;
    logic [AW-1:0] ab_wa, ab_ra;
    logic [8:0]    ab_rd;

    gcab_ram #(.Depth(MAX_EDGES), .Width(8)) u_esrc (.i_clk, .i_we(es_we),
        .i_waddr(n_le[EW-1:0]), .i_wdata(r_item.from_vertex), .i_raddr(r_e),
        .o_rdata(es_rd));
    gcab_ram #(.Depth(MAX_EDGES), .Width(8)) u_etgt (.i_clk, .i_we(es_we),
        .i_waddr(n_le[EW-1:0]), .i_wdata(r_item.to_vertex), .i_raddr(r_e),
        .o_rdata(et_rd));
    gcab_ram #(.Depth(MAX_VERTICES), .Width(10)) u_odeg (.i_clk, .i_we(od_we),
        .i_waddr(od_wa), .i_wdata(od_wd), .i_raddr(od_ra), .o_rdata(od_rd));
    gcab_ram #(.Depth(MAX_VERTICES), .Width(10)) u_ideg (.i_clk, .i_we(id_we),
        .i_waddr(id_wa), .i_wdata(id_wd), .i_raddr(id_ra), .o_rdata(id_rd));
    gcab_ram #(.Depth(MAX_VERTICES), .Width(10)) u_ooff (.i_clk, .i_we(of_we),
        .i_waddr(r_v), .i_wdata(r_run_out[9:0]), .i_raddr(q_vtx), .o_rdata(oo_rd));
    gcab_ram #(.Depth(MAX_VERTICES), .Width(11)) u_ioff (.i_clk, .i_we(of_we),
        .i_waddr(r_v), .i_wdata(r_run_in), .i_raddr(q_vtx), .o_rdata(io_rd));
    gcab_ram #(.Depth(MAX_VERTICES), .Width(10)) u_ocur (.i_clk, .i_we(oc_we),
        .i_waddr(oc_wa), .i_wdata(oc_wd), .i_raddr(es_rd), .o_rdata(oc_rd));
    gcab_ram #(.Depth(MAX_VERTICES), .Width(11)) u_icur (.i_clk, .i_we(ic_we),
        .i_waddr(ic_wa), .i_wdata(ic_wd), .i_raddr(et_rd), .o_rdata(ic_rd));
    gcab_ram #(.Depth(2*MAX_EDGES), .Width(9)) u_adj (.i_clk, .i_we(ab_we),
        .i_waddr(ab_wa), .i_wdata(r_e), .i_raddr(ab_ra), .o_rdata(ab_rd));

    function automatic logic vok(input logic [9:0] v, input logic [8:0] vc);
        return ({1'b0, v} < {2'b0, vc}) && (v < 10'(MAX_VERTICES));
    endfunction

    // query addresses come straight from the bus in the accepting cycle and
    // from the held item while the result waits
    t_in_item w_q;
    assign w_q   = (r_state == S_IDLE) ? w_in : r_item;
    assign q_vtx = w_q.query_index[VW-1:0];
    assign ab_ra = w_q.query_index;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {1'b0, r_res};

    // result register loads when the output side is free
    logic       w_res_load;
    logic [9:0] n_le;           // edges held before this add
    logic       w_vtx_ok;
    logic       w_store;
    t_out_item  n_res;

    assign w_res_load = ((r_state == S_ADD) || (r_state == S_QRY)) &&
                        (!r_ovalid || m_axis_tready);

    always_comb begin
        n_le     = r_built ? 10'd0 : r_loaded;     // add after a build: new graph
        w_vtx_ok = vok({2'b0, r_item.from_vertex}, r_vcount) &&
                   vok({2'b0, r_item.to_vertex}, r_vcount);
        w_store  = w_vtx_ok && (n_le < 10'(MAX_EDGES));
        n_res    = '0;
        if (r_state == S_ADD) begin
            if (!w_vtx_ok) begin
                n_res.status = ST_VERTEX;
            end else if (!w_store) begin
                n_res.status = ST_FULL;
            end else begin
                n_res.edge_id = n_le[8:0];
            end
            n_res.edge_total = n_le + {9'd0, w_store};
        end else begin
            n_res.edge_total = r_loaded;
            case (t_func'(r_item.func))
                FN_SLOT: begin
                    if (!r_built) begin
                        n_res.status = ST_UNBUILT;
                    end else if ({1'b0, r_item.query_index} >= {r_loaded, 1'b0}) begin
                        n_res.status = ST_QUERY;
                    end else begin
                        n_res.edge_id = ab_rd;
                    end
                end
                FN_VERT: begin
                    if (!r_built) begin
                        n_res.status = ST_UNBUILT;
                    end else if (!vok(r_item.query_index, r_vcount)) begin
                        n_res.status = ST_QUERY;
                    end else begin
                        n_res.out_start = oo_rd;
                        n_res.out_count = od_rd;
                        n_res.in_start  = io_rd;
                        n_res.in_count  = id_rd;
                    end
                end
                default: n_res.status = ST_QUERY;     // unknown func
            endcase
        end
    end

    // memory control
    always_comb begin
        es_we = 1'b0;
        od_we = 1'b0; id_we = 1'b0;
        od_wa = es_rd; id_wa = et_rd;
        od_ra = q_vtx; id_ra = q_vtx;
        od_wd = od_rd + 10'd1; id_wd = id_rd + 10'd1;
        of_we = 1'b0;
        oc_we = 1'b0; ic_we = 1'b0;
        oc_wa = es_rd; ic_wa = et_rd;
        oc_wd = oc_rd + 10'd1; ic_wd = ic_rd + 11'd1;
        ab_we = 1'b0; ab_wa = oc_rd;
        case (r_state)
            S_ADD: begin
                es_we = w_res_load && w_store;
            end
            S_CLR: begin
                od_we = 1'b1; id_we = 1'b1;
                od_wa = r_v; id_wa = r_v;
                od_wd = '0; id_wd = '0;
            end
            S_CNT_D: begin
                od_ra = es_rd; id_ra = et_rd;
            end
            S_CNT_W: begin
                // degree read-modify-write at both endpoints
                od_ra = es_rd; id_ra = et_rd;
                od_we = 1'b1; id_we = 1'b1;
            end
            S_SUM_R: begin
                od_ra = r_v; id_ra = r_v;
            end
            S_SUM_W: begin
                od_ra = r_v; id_ra = r_v;
                of_we = 1'b1; oc_we = 1'b1; ic_we = 1'b1;
                oc_wa = r_v; ic_wa = r_v;
                oc_wd = r_run_out[9:0]; ic_wd = r_run_in;
            end
            S_SC_WO: begin
                ab_we = 1'b1; oc_we = 1'b1;
            end
            S_SC_WI: begin
                ab_we = 1'b1; ab_wa = ic_rd[AW-1:0]; ic_we = 1'b1;
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_vcount  <= 9'd1;
            r_loaded  <= '0;
            r_built   <= 1'b0;
            r_ovalid  <= 1'b0;
            r_item    <= '0;
            r_res     <= '0;
            r_e       <= '0;
            r_v       <= '0;
            r_run_out <= '0;
            r_run_in  <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) r_vcount <= i_cfg_data;
            r_ovalid <= w_res_load || (r_ovalid && !m_axis_tready);
            if (w_res_load) r_res <= n_res;
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_item  <= w_in;
                        r_state <= (t_func'(w_in.func) == FN_ADD) ? S_ADD : S_QRY;
                    end
                end
                S_ADD: begin
                    if (w_res_load) begin
                        r_loaded <= n_res.edge_total;
                        r_built  <= 1'b0;
                        // build whenever edges are held, even if this one was rejected
                        if (r_item.last_edge && (n_res.edge_total != 10'd0)) begin
                            r_v     <= '0;
                            r_state <= S_CLR;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_QRY: begin
                    if (w_res_load) r_state <= S_IDLE;
                end
                S_CLR: begin
                    r_v <= r_v + 1'b1;
                    if (r_v == VMAX) begin
                        r_e     <= '0;
                        r_state <= S_CNT_E;
                    end
                end
                S_CNT_E: r_state <= S_CNT_D;    // edge endpoints read
                S_CNT_D: r_state <= S_CNT_W;    // degree read
                S_CNT_W: begin
                    r_e <= r_e + 1'b1;
                    if ({1'b0, r_e} == r_loaded - 10'd1) begin
                        r_v       <= '0;
                        r_run_out <= '0;
                        r_run_in  <= {1'b0, r_loaded};  // in-lists follow out-lists
                        r_state   <= S_SUM_R;
                    end else begin
                        r_state <= S_CNT_E;
                    end
                end
                S_SUM_R: r_state <= S_SUM_W;
                S_SUM_W: begin
                    r_run_out <= r_run_out + {1'b0, od_rd};
                    r_run_in  <= r_run_in + {1'b0, id_rd};
                    r_v       <= r_v + 1'b1;
                    if (r_v == VMAX) begin
                        r_e     <= '0;
                        r_state <= S_SC_E;
                    end else begin
                        r_state <= S_SUM_R;
                    end
                end
                S_SC_E:  r_state <= S_SC_C;     // edge endpoints read
                S_SC_C:  r_state <= S_SC_WO;    // cursor read
                S_SC_WO: r_state <= S_SC_WI;
                S_SC_WI: begin
                    r_e <= r_e + 1'b1;
                    if ({1'b0, r_e} == r_loaded - 10'd1) begin
                        r_built <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_SC_E;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata));
    a_loaded_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_loaded <= 10'(MAX_EDGES));
    a_built_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_built |-> r_loaded != 10'd0);
`endif
endmodule
